// ----- rtl/core/tchp_pkg.sv -----
// ----------------------------------------------------------------------------
// tchp_pkg
// Types, state codes and fixed handshake strings for the text command
// handshake parser.
// ----------------------------------------------------------------------------
package tchp_pkg;

	localparam int CHAR_W = 8;
	localparam int PROTO_W = 4;
	localparam int POS_W = 3;
	localparam int IDLE_W = 17;
	localparam int TMO_W = 16;
	localparam int KIND_W = 3;
	localparam int FUNC_W = 2;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [FUNC_W-1:0] FN_CHAR = 2'd0;
	localparam logic [FUNC_W-1:0] FN_TICK = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REPLY = 2'd2;

	// protocol states
	localparam logic [PROTO_W-1:0] ST_HELLO = 4'd0;
	localparam logic [PROTO_W-1:0] ST_VER = 4'd1;
	localparam logic [PROTO_W-1:0] ST_CAP = 4'd2;
	localparam logic [PROTO_W-1:0] ST_GHELLO = 4'd3;
	localparam logic [PROTO_W-1:0] ST_GET = 4'd4;
	localparam logic [PROTO_W-1:0] ST_GCOD = 4'd5;
	localparam logic [PROTO_W-1:0] ST_GURI = 4'd6;
	localparam logic [PROTO_W-1:0] ST_SCODE = 4'd7;
	localparam logic [PROTO_W-1:0] ST_SURI = 4'd8;
	localparam logic [PROTO_W-1:0] ST_SERR = 4'd9;

	// reply kinds
	localparam logic [KIND_W-1:0] RK_NONE = 3'd0;
	localparam logic [KIND_W-1:0] RK_CAP_NONE = 3'd1;
	localparam logic [KIND_W-1:0] RK_CAP_URI = 3'd2;
	localparam logic [KIND_W-1:0] RK_CAP_CODE = 3'd3;
	localparam logic [KIND_W-1:0] RK_CAP_BOTH = 3'd4;
	localparam logic [KIND_W-1:0] RK_CODE = 3'd5;
	localparam logic [KIND_W-1:0] RK_URI = 3'd6;
	localparam logic [KIND_W-1:0] RK_ERR = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_URI = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_CODE = 2'd2;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd60000;
	localparam logic [IDLE_W-1:0] IDLE_MAX = 17'h1ffff;

	localparam logic [POS_W-1:0] GET_LEN = 3'd3;

	localparam logic [CHAR_W-1:0] CH_P = 8'h50;
	localparam logic [CHAR_W-1:0] CH_C = 8'h43;
	localparam logic [CHAR_W-1:0] CH_U = 8'h55;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAR_W-1:0] char_in;
	} tchp_cmd_t;

	typedef struct packed {
		logic take_control;
		logic busy_res;
		logic [KIND_W-1:0] reply_kind;
	} tchp_res_t;

	typedef struct packed {
		logic [PROTO_W-1:0] proto;
		logic [POS_W-1:0] pos;
		logic [IDLE_W-1:0] idle_ms;
	} tchp_state_t;

	typedef struct packed {
		logic [TMO_W-1:0] timeout_ms;
		logic has_uri;
		logic has_code_source;
	} tchp_cfg_t;

	// length of the string matched in a given state, zero where none applies
	function automatic logic [POS_W-1:0] str_len(input logic [PROTO_W-1:0] st);
		logic [POS_W-1:0] len;
		case (st)
			ST_HELLO, ST_GHELLO: len = 3'd5;
			ST_VER: len = 3'd4;
			ST_GET, ST_GCOD, ST_GURI: len = 3'd3;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// expected character at a match position in a given state
	function automatic logic [CHAR_W-1:0] str_char(input logic [PROTO_W-1:0] st,
		input logic [POS_W-1:0] pos);
		logic [CHAR_W-1:0] ch;
		ch = 8'h00;
		case (st)
			ST_HELLO, ST_GHELLO: begin
				case (pos)
					3'd0: ch = 8'h50;
					3'd1: ch = 8'h4c;
					3'd2: ch = 8'h43;
					3'd3: ch = 8'h55;
					3'd4: ch = 8'h50;
					default: ch = 8'h00;
				endcase
			end
			ST_VER: begin
				case (pos)
					3'd0: ch = 8'h2f;
					3'd1: ch = 8'h30;
					3'd2: ch = 8'h2e;
					3'd3: ch = 8'h31;
					default: ch = 8'h00;
				endcase
			end
			ST_GET: begin
				case (pos)
					3'd0: ch = 8'h20;
					3'd1: ch = 8'h47;
					3'd2: ch = 8'h20;
					default: ch = 8'h00;
				endcase
			end
			ST_GCOD: begin
				case (pos)
					3'd0: ch = 8'h43;
					3'd1: ch = 8'h4f;
					3'd2: ch = 8'h44;
					default: ch = 8'h00;
				endcase
			end
			ST_GURI: begin
				case (pos)
					3'd0: ch = 8'h55;
					3'd1: ch = 8'h52;
					3'd2: ch = 8'h49;
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/core/text_command_handshake_parser.sv -----
// ----------------------------------------------------------------------------
// text_command_handshake_parser
// Path: a command word is registered in the input stage, its result in the result
// register. Throughput: one word per cycle unless the result side stalls.
// Reset: protocol state awaits the hello word, match position and idle count
// are zero, timeout is 60000 ms, no URI or code source configured.
// ----------------------------------------------------------------------------
module text_command_handshake_parser import tchp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input tchp_cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output tchp_res_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [TMO_W-1:0] cfg_data
);

	logic valid_s1;
	tchp_cmd_t cmd_s1;
	tchp_state_t state_q;
	tchp_state_t state_nxt;
	tchp_cfg_t cfg_q;
	logic res_valid_q;
	tchp_res_t res_q;
	tchp_res_t res_nxt;
	logic adv;
	logic cmd_acc;
	logic fire;

	assign adv = !res_valid_q || !res_stall;
	assign cmd_stall = valid_s1 && !adv;
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign fire = valid_s1 && adv;
	assign cfg_ready = 1'b1;

	tchp_step u_step (
		.st(state_q),
		.cfg(cfg_q),
		.cmd(cmd_s1),
		.st_nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.proto <= ST_HELLO;
			state_q.pos <= '0;
			state_q.idle_ms <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= TIMEOUT_RST;
			cfg_q.has_uri <= 1'b0;
			cfg_q.has_code_source <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIMEOUT: cfg_q.timeout_ms <= cfg_data;
				CFG_HAS_URI: cfg_q.has_uri <= cfg_data[0];
				CFG_HAS_CODE: cfg_q.has_code_source <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// stall only while a word is held in the input stage
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1)
		else $error("input stall without a held word");

	a_proto_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.proto <= ST_SERR)
		else $error("protocol state out of range");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= 3'd4)
		else $error("match position out of range");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q))
		else $error("state changed without a processed word");

	a_reply_only_on_reply: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd_s1.func != FN_REPLY) |=> res_q.reply_kind == RK_NONE)
		else $error("reply kind on a non-reply word");

endmodule

// ----- rtl/core/tchp_step.sv -----
// ----------------------------------------------------------------------------
// tchp_step
// Next-state and result logic for one command word: character matching,
// idle timeout, tick counting and reply selection.
// ----------------------------------------------------------------------------
module tchp_step import tchp_pkg::*; (
	input tchp_state_t st,
	input tchp_cfg_t cfg,
	input tchp_cmd_t cmd,
	output tchp_state_t st_nxt,
	output tchp_res_t res
);

	logic any_cfg;
	logic hit;
	logic [POS_W-1:0] len;
	logic [POS_W-1:0] pos_inc;
	logic timed_out;
	logic [KIND_W-1:0] kind;
	tchp_state_t nxt;

	assign any_cfg = cfg.has_uri | cfg.has_code_source;
	assign len = str_len(st.proto);
	assign hit = (st.pos < len) && (str_char(st.proto, st.pos) == cmd.char_in);
	assign pos_inc = st.pos + 3'd1;
	assign timed_out = (st.proto != ST_HELLO) && (st.idle_ms > {1'b0, cfg.timeout_ms});

	always_comb begin
		nxt = st;
		kind = RK_NONE;
		case (cmd.func)
			FN_CHAR: begin
				if (timed_out) begin
					nxt.proto = ST_SERR;
				end else begin
					nxt.idle_ms = '0;
					case (st.proto)
						ST_HELLO: begin
							if (!hit) begin
								nxt.pos = '0;
							end else if (pos_inc == len) begin
								nxt.pos = '0;
								nxt.proto = ST_VER;
							end else begin
								nxt.pos = pos_inc;
							end
						end
						ST_VER, ST_GHELLO, ST_GCOD, ST_GURI: begin
							if (!hit) begin
								nxt.pos = '0;
								nxt.proto = ST_SERR;
							end else if (pos_inc == len) begin
								nxt.pos = '0;
								case (st.proto)
									ST_VER: nxt.proto = ST_CAP;
									ST_GHELLO: nxt.proto = ST_GET;
									ST_GCOD: nxt.proto = ST_SCODE;
									default: nxt.proto = ST_SURI;
								endcase
							end else begin
								nxt.pos = pos_inc;
							end
						end
						ST_CAP: begin
							if (cmd.char_in == CH_P) begin
								nxt.pos = 3'd1;
								nxt.proto = any_cfg ? ST_GHELLO : ST_HELLO;
							end else begin
								nxt.pos = '0;
								nxt.proto = any_cfg ? ST_SERR : ST_HELLO;
							end
						end
						ST_GET: begin
							if (st.pos >= GET_LEN) begin
								if (cmd.char_in == CH_C) begin
									nxt.pos = 3'd1;
									nxt.proto = ST_GCOD;
								end else if (cmd.char_in == CH_U) begin
									nxt.pos = 3'd1;
									nxt.proto = ST_GURI;
								end else begin
									nxt.pos = '0;
									nxt.proto = ST_SERR;
								end
							end else if (hit) begin
								nxt.pos = pos_inc;
							end else begin
								nxt.pos = '0;
								nxt.proto = ST_SERR;
							end
						end
						default: begin
							nxt.pos = (cmd.char_in == CH_P) ? 3'd1 : 3'd0;
							nxt.proto = ST_HELLO;
						end
					endcase
				end
			end
			FN_TICK: begin
				if (st.idle_ms != IDLE_MAX) begin
					nxt.idle_ms = st.idle_ms + 17'd1;
				end
			end
			FN_REPLY: begin
				case (st.proto)
					ST_CAP: begin
						if (any_cfg) begin
							nxt.proto = ST_GHELLO;
							if (cfg.has_uri && cfg.has_code_source) begin
								kind = RK_CAP_BOTH;
							end else if (cfg.has_uri) begin
								kind = RK_CAP_URI;
							end else begin
								kind = RK_CAP_CODE;
							end
						end else begin
							nxt.proto = ST_HELLO;
							kind = RK_CAP_NONE;
						end
					end
					ST_SCODE: begin
						nxt.proto = ST_HELLO;
						kind = RK_CODE;
					end
					ST_SURI: begin
						nxt.proto = ST_HELLO;
						kind = RK_URI;
					end
					ST_SERR: begin
						nxt.proto = ST_HELLO;
						kind = RK_ERR;
					end
					default: kind = RK_NONE;
				endcase
			end
			default: nxt = st;
		endcase
	end

	assign st_nxt = nxt;
	assign res.take_control = (nxt.proto == ST_CAP) || (nxt.proto == ST_SCODE) ||
		(nxt.proto == ST_SURI) || (nxt.proto == ST_SERR);
	assign res.busy_res = !((nxt.proto == ST_HELLO) || (nxt.proto == ST_SCODE) ||
		(nxt.proto == ST_SURI) || (nxt.proto == ST_SERR) ||
		((nxt.proto == ST_CAP) && !any_cfg));
	assign res.reply_kind = kind;

endmodule

// ----- test/text_command_handshake_parser_test.sv -----
// ----------------------------------------------------------------------------
// text_command_handshake_parser_test
// Self-checking bench for the handshake parser. Command words are received
// characters, millisecond ticks and reply requests: a short directed run,
// then mostly well-formed handshake exchanges with random damage, noise and
// tick bursts under eight register settings and four idling mixes. A
// scoreboard predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module text_command_handshake_parser_test;
	import tchp_pkg::*;

	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 180;
	localparam int TMO_SET [8] = '{60000, 65535, 0, 5, 3, 8, 20, 0};
	localparam bit URI_SET [8] = '{0, 1, 1, 0, 1, 0, 1, 0};
	localparam bit CODE_SET [8] = '{0, 1, 0, 1, 1, 0, 0, 1};
	localparam int GAP_SET [4] = '{0, 49, 0, 34};
	localparam int STALL_SET [4] = '{0, 0, 49, 34};

	class reply_scoreboard;
		typedef enum {MISS, PART, FULL} match_t;

		tchp_cfg_t cfg;
		logic [PROTO_W-1:0] proto;
		logic [POS_W-1:0] pos;
		logic [IDLE_W-1:0] idle;
		string hello_s, ver_s, get_s, cod_s, uri_s;
		tchp_res_t results_due[$];
		int mismatches;
		int checked;
		int kind_seen[8];

		function new();
			cfg.timeout_ms = TIMEOUT_RST;
			cfg.has_uri = 1'b0;
			cfg.has_code_source = 1'b0;
			proto = ST_HELLO;
			pos = '0;
			idle = '0;
			hello_s = {"P", "LCU", "P"};
			ver_s = "/0.1";
			get_s = " G ";
			cod_s = "COD";
			uri_s = "URI";
			mismatches = 0;
			checked = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [TMO_W-1:0] data);
			case (idx)
				CFG_TIMEOUT: cfg.timeout_ms = data;
				CFG_HAS_URI: cfg.has_uri = data[0];
				CFG_HAS_CODE: cfg.has_code_source = data[0];
				default: ;
			endcase
		endfunction

		function bit any_source();
			return cfg.has_uri || cfg.has_code_source;
		endfunction

		function match_t step_match(string s, logic [CHAR_W-1:0] c);
			if (pos < s.len() && s[pos] == c) begin
				pos++;
				if (pos == s.len()) begin
					pos = '0;
					return FULL;
				end
				return PART;
			end
			pos = '0;
			return MISS;
		endfunction

		function void step_strict(string s, logic [CHAR_W-1:0] c, logic [PROTO_W-1:0] nxt_st);
			match_t m;
			m = step_match(s, c);
			if (m == MISS)
				proto = ST_SERR;
			else if (m == FULL)
				proto = nxt_st;
		endfunction

		function void take_char(logic [CHAR_W-1:0] c);
			if (proto != ST_HELLO && idle > {1'b0, cfg.timeout_ms}) begin
				proto = ST_SERR;
				return;
			end
			idle = '0;
			case (proto)
				ST_HELLO: begin
					if (step_match(hello_s, c) == FULL) proto = ST_VER;
				end
				ST_VER: step_strict(ver_s, c, ST_CAP);
				ST_CAP: begin
					if (c == CH_P) begin
						pos = 3'd1;
						proto = any_source() ? ST_GHELLO : ST_HELLO;
					end else begin
						pos = '0;
						proto = any_source() ? ST_SERR : ST_HELLO;
					end
				end
				ST_GHELLO: step_strict(hello_s, c, ST_GET);
				ST_GET: begin
					if (pos >= GET_LEN) begin
						if (c == CH_C) begin
							pos = 3'd1;
							proto = ST_GCOD;
						end else if (c == CH_U) begin
							pos = 3'd1;
							proto = ST_GURI;
						end else begin
							pos = '0;
							proto = ST_SERR;
						end
					end else if (get_s[pos] == c) begin
						pos++;
					end else begin
						pos = '0;
						proto = ST_SERR;
					end
				end
				ST_GCOD: step_strict(cod_s, c, ST_SCODE);
				ST_GURI: step_strict(uri_s, c, ST_SURI);
				default: begin
					pos = (c == CH_P) ? 3'd1 : 3'd0;
					proto = ST_HELLO;
				end
			endcase
		endfunction

		function logic [KIND_W-1:0] take_reply();
			case (proto)
				ST_CAP: begin
					if (any_source()) begin
						proto = ST_GHELLO;
						if (cfg.has_uri && cfg.has_code_source) return RK_CAP_BOTH;
						return cfg.has_uri ? RK_CAP_URI : RK_CAP_CODE;
					end
					proto = ST_HELLO;
					return RK_CAP_NONE;
				end
				ST_SCODE: begin
					proto = ST_HELLO;
					return RK_CODE;
				end
				ST_SURI: begin
					proto = ST_HELLO;
					return RK_URI;
				end
				ST_SERR: begin
					proto = ST_HELLO;
					return RK_ERR;
				end
				default: return RK_NONE;
			endcase
		endfunction

		function void note_cmd(tchp_cmd_t w);
			tchp_res_t r;
			r.reply_kind = RK_NONE;
			case (w.func)
				FN_CHAR: take_char(w.char_in);
				FN_TICK: if (idle != IDLE_MAX) idle++;
				FN_REPLY: r.reply_kind = take_reply();
				default: ;
			endcase
			r.take_control = proto inside {ST_CAP, ST_SCODE, ST_SURI, ST_SERR};
			r.busy_res = !(proto inside {ST_HELLO, ST_SCODE, ST_SURI, ST_SERR} ||
				(proto == ST_CAP && !any_source()));
			results_due.push_back(r);
		endfunction

		function void check_res(tchp_res_t got);
			tchp_res_t exp;
			if (results_due.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				mismatches++;
				return;
			end
			exp = results_due.pop_front();
			checked++;
			kind_seen[exp.reply_kind]++;
			if (got.take_control !== exp.take_control) begin
				$error("take_control expected %0d got %0d", exp.take_control, got.take_control);
				mismatches++;
			end
			if (got.busy_res !== exp.busy_res) begin
				$error("busy_res expected %0d got %0d", exp.busy_res, got.busy_res);
				mismatches++;
			end
			if (got.reply_kind !== exp.reply_kind) begin
				$error("reply_kind expected %0d got %0d", exp.reply_kind, got.reply_kind);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	tchp_cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	tchp_res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TMO_W-1:0] cfg_data = '0;

	reply_scoreboard sb;
	tchp_cmd_t plan[$];
	string protocol_chars = "PLCU/0.1 GODRI";
	int hold_left = 0;
	int stall_pct = 0;
	int gap_pct = 0;
	int words_sent = 0;

	text_command_handshake_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall) sb.note_cmd(cmd);
		if (res_valid && !res_stall) sb.check_res(res);
	end

	// result side stall, with a long hold-off when requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		#10000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic tchp_cmd_t make_word(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] c);
		tchp_cmd_t w;
		w.func = f;
		w.char_in = c;
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		if ($urandom_range(1) == 0) return CHAR_W'($urandom_range(255));
		return protocol_chars[$urandom_range(protocol_chars.len() - 1)];
	endfunction

	function automatic tchp_cmd_t noise_word();
		int r;
		r = $urandom_range(99);
		return make_word(r < 60 ? FN_CHAR : r < 75 ? FN_TICK : r < 90 ? FN_REPLY : FN_UNUSED,
			pick_char());
	endfunction

	function automatic int tick_span();
		return (sb.cfg.timeout_ms <= 40) ? int'(sb.cfg.timeout_ms) + 2 : 3;
	endfunction

	function automatic void plan_text(string s);
		foreach (s[i]) plan.push_back(make_word(FN_CHAR, s[i]));
	endfunction

	task automatic drive_word(input tchp_cmd_t w);
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i]) drive_word(make_word(FN_CHAR, s[i]));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) drive_word(make_word(FN_TICK, pick_char()));
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TMO_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [TMO_W-1:0] tmo, input logic uri, input logic code);
		put_reg(CFG_TIMEOUT, tmo);
		put_reg(CFG_HAS_URI, TMO_W'(uri));
		put_reg(CFG_HAS_CODE, TMO_W'(code));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.results_due.size() != 0) @(posedge clk);
	endtask

	// one handshake exchange, sometimes damaged, sometimes with idle ticks
	task automatic run_exchange();
		bit skip_cap_reply;
		int at;
		plan.delete();
		plan_text(sb.hello_s);
		plan_text(sb.ver_s);
		skip_cap_reply = ($urandom_range(7) == 0);
		if (!skip_cap_reply) plan.push_back(make_word(FN_REPLY, pick_char()));
		if (skip_cap_reply || sb.any_source() || $urandom_range(3) == 0) begin
			plan_text(sb.hello_s);
			plan_text(sb.get_s);
			plan_text($urandom_range(1) ? sb.cod_s : sb.uri_s);
			plan.push_back(make_word(FN_REPLY, pick_char()));
		end
		if ($urandom_range(2) == 0) begin
			at = $urandom_range(plan.size() - 1);
			plan[at] = noise_word();
		end
		foreach (plan[i]) begin
			if ($urandom_range(9) == 0) send_ticks($urandom_range(1, tick_span()));
			drive_word(plan[i]);
		end
	endtask

	initial begin
		int start;
		int sel;
		logic [TMO_W-1:0] tmo;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		drive_word(make_word(FN_CHAR, 8'h00));
		drive_word(make_word(FN_CHAR, 8'hff));
		drive_word(make_word(FN_UNUSED, 8'haa));
		drive_word(make_word(FN_TICK, 8'h55));
		drive_word(make_word(FN_REPLY, 8'h00));
		send_text("PLP");
		send_text(sb.hello_s);
		send_text(sb.ver_s);
		drive_word(make_word(FN_REPLY, 8'hff));

		// long result hold-off while words keep coming
		hold_left <= 300;
		repeat (60) drive_word(noise_word());

		for (int k = 0; k < 8; k++) begin
			wait_drained();
			gap_pct = GAP_SET[k / 2];
			stall_pct <= STALL_SET[k / 2];
			if (k != 0) begin
				tmo = (k == 7) ? TMO_W'($urandom_range(30)) : TMO_W'(TMO_SET[k]);
				apply_setting(tmo, URI_SET[k], CODE_SET[k]);
			end
			start = words_sent;
			while (words_sent - start < RANDOM_WORDS) begin
				sel = $urandom_range(99);
				if (sel < 65)
					run_exchange();
				else if (sel < 85)
					repeat ($urandom_range(1, 6)) drive_word(noise_word());
				else
					send_ticks($urandom_range(1, tick_span()));
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		$display("covered %0d result words over eight register settings and four idling mixes",
			sb.checked);
		$display("reply kinds 0 to 7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6], sb.kind_seen[7]);
		if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
